[design/tebc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tebc_pkg;

    localparam int FRAC       = 16;         // internal fraction bits
    localparam int AW         = 48;         // multiplicand / value width
    localparam int DW         = 4;          // multiplier digit width
    localparam int ND         = 9;          // digits per multiply
    localparam int BW         = DW * ND;    // multiplier operand width
    localparam int PW         = AW + BW;    // full product width
    localparam int DCW        = $clog2(ND);
    localparam int CW         = 44;         // CORDIC x/y width
    localparam int ZW         = 20;         // CORDIC angle width
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IW    = 5;
    localparam int DEF_STEPS  = 16;

    // register indexes
    localparam logic [2:0] REG_FILTER_COEFF  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [2:0] REG_ACCEL_RATIO   = 3'd2;
    localparam logic [2:0] REG_ANGLE_BIAS    = 3'd3;
    localparam logic [2:0] REG_GAIN_ANGLE    = 3'd4;
    localparam logic [2:0] REG_GAIN_RATE     = 3'd5;
    localparam logic [2:0] REG_GAIN_WHEEL    = 3'd6;
    localparam logic [2:0] REG_ANGLE_LIMIT   = 3'd7;

    // multiply sequence
    localparam logic [3:0] OP_X1    = 4'd0;
    localparam logic [3:0] OP_Y1    = 4'd1;
    localparam logic [3:0] OP_P1    = 4'd2;
    localparam logic [3:0] OP_X2    = 4'd3;
    localparam logic [3:0] OP_Y2    = 4'd4;
    localparam logic [3:0] OP_P2    = 4'd5;
    localparam logic [3:0] OP_PSI   = 4'd6;
    localparam logic [3:0] OP_NUM   = 4'd7;
    localparam logic [3:0] OP_DEN   = 4'd8;
    localparam logic [3:0] OP_PRED  = 4'd9;
    localparam logic [3:0] OP_TGYR  = 4'd10;
    localparam logic [3:0] OP_TACC  = 4'd11;
    localparam logic [3:0] OP_UANG  = 4'd12;
    localparam logic [3:0] OP_URATE = 4'd13;
    localparam logic [3:0] OP_UWHL  = 4'd14;

    // calibration, Q16
    localparam logic signed [AW-1:0] GAIN_X1    = -48'sd2543136;
    localparam logic signed [AW-1:0] OFFS_X1    = 48'sd2156503079;
    localparam logic signed [AW-1:0] GAIN_Y1    = 48'sd2442677;
    localparam logic signed [AW-1:0] OFFS_Y1    = 48'sd1740320748;
    localparam logic signed [AW-1:0] GAIN_X2    = -48'sd2542878;
    localparam logic signed [AW-1:0] OFFS_X2    = -48'sd130996503;
    localparam logic signed [AW-1:0] GAIN_Y2    = 48'sd2556708;
    localparam logic signed [AW-1:0] OFFS_Y2    = 48'sd435080187;
    localparam logic signed [AW-1:0] GAIN_GYRO  = 48'sd4459721;
    localparam logic signed [AW-1:0] OFFS_GYRO1 = -48'sd41690367;
    localparam logic signed [AW-1:0] OFFS_GYRO2 = -48'sd27202517;
    localparam logic signed [AW-1:0] GAIN_WHL   = -48'sd2202322864;
    localparam logic signed [AW-1:0] OFFS_WHL   = 48'sd4483340266635;
    localparam logic signed [AW-1:0] ROUND_HALF = 48'sd32768;
    localparam logic signed [AW-1:0] HALF_PI    = 48'sd102944;

    // config reset values
    localparam logic [16:0] RST_FILTER_COEFF  = 17'd64225;
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd1311;
    localparam logic [31:0] RST_ACCEL_RATIO   = 32'd150413;
    localparam logic [31:0] RST_ANGLE_BIAS    = 32'd524;
    localparam logic [31:0] RST_GAIN_ANGLE    = 32'hFFFE_7197;
    localparam logic [31:0] RST_GAIN_RATE     = 32'hFFFF_BAFC;
    localparam logic [31:0] RST_GAIN_WHEEL    = 32'hFFFF_FFDD;
    localparam logic [30:0] RST_ANGLE_LIMIT   = 31'd22876;

    // atan(2^-i), Q32
    function automatic logic [33:0] atan_q32(input logic [ATAN_IW-1:0] i);
        logic [33:0] r;
        case (i)
            5'd0:  r = 34'd3373259426;
            5'd1:  r = 34'd1991351318;
            5'd2:  r = 34'd1052175346;
            5'd3:  r = 34'd534100635;
            5'd4:  r = 34'd268086748;
            5'd5:  r = 34'd134174063;
            5'd6:  r = 34'd67103403;
            5'd7:  r = 34'd33553749;
            5'd8:  r = 34'd16777131;
            5'd9:  r = 34'd8388597;
            5'd10: r = 34'd4194303;
            5'd11: r = 34'd2097152;
            5'd12: r = 34'd1048576;
            5'd13: r = 34'd524288;
            5'd14: r = 34'd262144;
            5'd15: r = 34'd131072;
            5'd16: r = 34'd65536;
            5'd17: r = 34'd32768;
            5'd18: r = 34'd16384;
            5'd19: r = 34'd8192;
            5'd20: r = 34'd4096;
            5'd21: r = 34'd2048;
            5'd22: r = 34'd1024;
            5'd23: r = 34'd512;
            default: r = 34'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -48'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[design/tilt_estimate_and_balance_control.sv]
// Each item runs 15 multiplies in sequence (a load, ND digit steps and a post
// step each), plus CORDIC_STEPS CORDIC steps and a final done step; the
// CORDIC pass is skipped when the denominator is zero.
// Only one item is in flight at a time, and one 4-bit-digit
// shift-add multiplier is shared by all products and one CORDIC rotator runs
// one step per cycle. A stalled result holds the block in its done state.
// Reset (rst_n low, async): registers at documented defaults, filter state 0.
`timescale 1ns / 1ps
`default_nettype none
module tilt_estimate_and_balance_control
    import tebc_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_STEPS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // config
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] accel1_x,
    input  wire logic signed [15:0] accel1_y,
    input  wire logic signed [15:0] gyro1_rate,
    input  wire logic signed [15:0] accel2_x,
    input  wire logic signed [15:0] accel2_y,
    input  wire logic signed [15:0] gyro2_rate,
    input  wire logic [11:0]        wheel_adc,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      torque_cmd,
    output logic signed [31:0]      tilt_angle,
    output logic                    drive_enabled
);

    localparam int CSW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_CORD = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // ---------------- configuration registers ----------------
    logic [16:0] filter_coeff_reg;
    logic [15:0] sample_period_reg;
    logic [31:0] accel_ratio_reg, angle_bias_reg, gain_angle_reg;
    logic [31:0] gain_rate_reg, gain_wheel_reg;
    logic [30:0] angle_limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_coeff_reg  <= RST_FILTER_COEFF;
            sample_period_reg <= RST_SAMPLE_PERIOD;
            accel_ratio_reg   <= RST_ACCEL_RATIO;
            angle_bias_reg    <= RST_ANGLE_BIAS;
            gain_angle_reg    <= RST_GAIN_ANGLE;
            gain_rate_reg     <= RST_GAIN_RATE;
            gain_wheel_reg    <= RST_GAIN_WHEEL;
            angle_limit_reg   <= RST_ANGLE_LIMIT;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_FILTER_COEFF:  filter_coeff_reg  <= pwdata[16:0];
                REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[15:0];
                REG_ACCEL_RATIO:   accel_ratio_reg   <= pwdata;
                REG_ANGLE_BIAS:    angle_bias_reg    <= pwdata;
                REG_GAIN_ANGLE:    gain_angle_reg    <= pwdata;
                REG_GAIN_RATE:     gain_rate_reg     <= pwdata;
                REG_GAIN_WHEEL:    gain_wheel_reg    <= pwdata;
                REG_ANGLE_LIMIT:   angle_limit_reg   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FILTER_COEFF:  prdata = {15'd0, filter_coeff_reg};
            REG_SAMPLE_PERIOD: prdata = {16'd0, sample_period_reg};
            REG_ACCEL_RATIO:   prdata = accel_ratio_reg;
            REG_ANGLE_BIAS:    prdata = angle_bias_reg;
            REG_GAIN_ANGLE:    prdata = gain_angle_reg;
            REG_GAIN_RATE:     prdata = gain_rate_reg;
            REG_GAIN_WHEEL:    prdata = gain_wheel_reg;
            REG_ANGLE_LIMIT:   prdata = {1'b0, angle_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- datapath registers ----------------
    logic [2:0]  state_reg;
    logic [3:0]  op_reg;
    logic [DCW-1:0] dig_cnt_reg;
    logic [CSW-1:0] cord_cnt_reg;

    logic [15:0] ax1_reg, ay1_reg, g1_reg, ax2_reg, ay2_reg, g2_reg;
    logic [11:0] adc_reg;

    logic signed [PW-1:0] mul_a_reg, acc_reg;
    logic [BW-1:0]        mul_b_reg;

    logic signed [AW-1:0] x1_reg, y1_reg, p1_reg, x2_reg, y2_reg;
    logic signed [AW-1:0] rate_reg, psi_reg, acc_tilt_reg, sum_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [31:0]   prev_tilt_reg;

    logic signed [31:0] torque_reg, tilt_reg;
    logic               en_reg, out_valid_reg;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign torque_cmd    = torque_reg;
    assign tilt_angle    = tilt_reg;
    assign drive_enabled = en_reg;

    // ---------------- operand select ----------------
    logic signed [AW-1:0] op_a, cal_off, bias_ext;
    logic [BW-1:0]        op_b;

    assign bias_ext = AW'($signed(angle_bias_reg));

    always_comb
    begin
        op_a    = '0;
        op_b    = '0;
        cal_off = '0;
        case (op_reg)
            OP_X1:
            begin
                op_a = GAIN_X1; op_b = {{(BW-16){ax1_reg[15]}}, ax1_reg};
                cal_off = OFFS_X1;
            end
            OP_Y1:
            begin
                op_a = GAIN_Y1; op_b = {{(BW-16){ay1_reg[15]}}, ay1_reg};
                cal_off = OFFS_Y1;
            end
            OP_P1:
            begin
                op_a = GAIN_GYRO; op_b = {{(BW-16){g1_reg[15]}}, g1_reg};
                cal_off = OFFS_GYRO1;
            end
            OP_X2:
            begin
                op_a = GAIN_X2; op_b = {{(BW-16){ax2_reg[15]}}, ax2_reg};
                cal_off = OFFS_X2;
            end
            OP_Y2:
            begin
                op_a = GAIN_Y2; op_b = {{(BW-16){ay2_reg[15]}}, ay2_reg};
                cal_off = OFFS_Y2;
            end
            OP_P2:
            begin
                op_a = GAIN_GYRO; op_b = {{(BW-16){g2_reg[15]}}, g2_reg};
                cal_off = OFFS_GYRO2;
            end
            OP_PSI:
            begin
                op_a = GAIN_WHL; op_b = {{(BW-12){1'b0}}, adc_reg};
                cal_off = OFFS_WHL;
            end
            OP_NUM:
            begin
                op_a = x2_reg; op_b = {{(BW-32){accel_ratio_reg[31]}}, accel_ratio_reg};
            end
            OP_DEN:
            begin
                op_a = y2_reg; op_b = {{(BW-32){accel_ratio_reg[31]}}, accel_ratio_reg};
            end
            OP_PRED:
            begin
                op_a = rate_reg; op_b = {{(BW-16){1'b0}}, sample_period_reg};
            end
            OP_TGYR:
            begin
                op_a = sum_reg; op_b = {{(BW-17){1'b0}}, filter_coeff_reg};
            end
            OP_TACC:
            begin
                // accel weight = 1.0 - coeff, may go negative
                op_a = acc_tilt_reg;
                op_b = BW'(65536) - {{(BW-17){1'b0}}, filter_coeff_reg};
            end
            OP_UANG:
            begin
                op_a = AW'(prev_tilt_reg);
                op_b = {{(BW-32){gain_angle_reg[31]}}, gain_angle_reg};
            end
            OP_URATE:
            begin
                op_a = rate_reg; op_b = {{(BW-32){gain_rate_reg[31]}}, gain_rate_reg};
            end
            OP_UWHL:
            begin
                op_a = psi_reg; op_b = {{(BW-32){gain_wheel_reg[31]}}, gain_wheel_reg};
            end
            default: ;
        endcase
    end

    // ---------------- digit-serial multiplier step ----------------
    // low digits unsigned, top digit carries the sign
    logic               dig_last;
    logic signed [DW:0] dig_s;
    logic signed [PW-1:0] step_prod;

    assign dig_last  = (dig_cnt_reg == DCW'(ND - 1));
    assign dig_s     = dig_last ? $signed({mul_b_reg[DW-1], mul_b_reg[DW-1:0]})
                                : $signed({1'b0, mul_b_reg[DW-1:0]});
    assign step_prod = mul_a_reg * dig_s;

    // ---------------- post-multiply values ----------------
    logic signed [AW-1:0] prod_q, cal_q, diff_q;
    logic signed [PW-1:0] cal_sum;

    assign prod_q  = AW'(acc_reg >>> FRAC);
    assign cal_sum = acc_reg + PW'(cal_off) + PW'(ROUND_HALF);
    assign cal_q   = AW'(cal_sum >>> FRAC);
    assign diff_q  = ((op_reg == OP_NUM) ? x1_reg : y1_reg) - prod_q;

    // ---------------- CORDIC step (vectoring, folded to +-pi/2) ----------------
    logic signed [CW-1:0] cdx, cdy, cx_nx, cy_nx;
    logic signed [ZW-1:0] z_nx, ang;
    logic [33:0]          ang_r;

    assign cdx   = cy_reg >>> cord_cnt_reg;
    assign cdy   = cx_reg >>> cord_cnt_reg;
    assign ang_r = (atan_q32(ATAN_IW'(cord_cnt_reg)) + 34'd32768) >> FRAC;
    assign ang   = ZW'(ang_r);

    always_comb
    begin
        if (cy_reg > 0)
        begin
            cx_nx = cx_reg + cdx;
            cy_nx = cy_reg - cdy;
            z_nx  = z_reg + ang;
        end
        else
        begin
            cx_nx = cx_reg - cdx;
            cy_nx = cy_reg + cdy;
            z_nx  = z_reg - ang;
        end
    end

    // ---------------- output values ----------------
    logic signed [32:0] tilt33, lim33;
    logic               en_nx;

    assign tilt33 = 33'(prev_tilt_reg);
    assign lim33  = {2'b00, angle_limit_reg};
    assign en_nx  = (tilt33 < lim33) && (tilt33 > -lim33);

    // ---------------- control and datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_X1;
            dig_cnt_reg   <= '0;
            cord_cnt_reg  <= '0;
            prev_tilt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a finished item loads the output once the previous result has gone
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= OP_X1;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    dig_cnt_reg <= '0;
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    dig_cnt_reg <= dig_cnt_reg + 1'b1;
                    if (dig_last)
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    op_reg <= op_reg + 1'b1;
                    if (op_reg == OP_TACC)
                        prev_tilt_reg <= sat32(sum_reg + prod_q);
                    if (op_reg == OP_DEN)
                        cord_cnt_reg <= '0;
                    if (op_reg == OP_UWHL)
                        state_reg <= S_DONE;
                    else if ((op_reg == OP_DEN) && (diff_q != 0))
                        state_reg <= S_CORD;
                    else
                        state_reg <= S_LOAD;
                end
                S_CORD:
                begin
                    cord_cnt_reg <= cord_cnt_reg + 1'b1;
                    if (cord_cnt_reg == CSW'(CORDIC_STEPS - 1))
                        state_reg <= S_LOAD;
                end
                S_DONE:
                begin
                    // hold until the previous result has been transferred
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ax1_reg <= accel1_x;
                    ay1_reg <= accel1_y;
                    g1_reg  <= gyro1_rate;
                    ax2_reg <= accel2_x;
                    ay2_reg <= accel2_y;
                    g2_reg  <= gyro2_rate;
                    adc_reg <= wheel_adc;
                end
            end
            S_LOAD:
            begin
                mul_a_reg <= PW'(op_a);
                mul_b_reg <= op_b;
                acc_reg   <= '0;
            end
            S_MUL:
            begin
                acc_reg   <= acc_reg + step_prod;
                mul_a_reg <= mul_a_reg <<< DW;
                mul_b_reg <= mul_b_reg >> DW;
            end
            S_POST:
            begin
                case (op_reg)
                    OP_X1:  x1_reg   <= cal_q;
                    OP_Y1:  y1_reg   <= cal_q;
                    OP_P1:  p1_reg   <= cal_q;
                    OP_X2:  x2_reg   <= cal_q;
                    OP_Y2:  y2_reg   <= cal_q;
                    OP_P2:  rate_reg <= (p1_reg + cal_q) >>> 1;
                    OP_PSI: psi_reg  <= cal_q;
                    OP_NUM: cy_reg   <= CW'(-diff_q);
                    OP_DEN:
                    begin
                        z_reg <= '0;
                        if (diff_q == 0)
                        begin
                            // vertical denominator: +-pi/2 by numerator sign
                            if (cy_reg > 0)
                                acc_tilt_reg <= HALF_PI + bias_ext;
                            else if (cy_reg < 0)
                                acc_tilt_reg <= bias_ext - HALF_PI;
                            else
                                acc_tilt_reg <= bias_ext;
                        end
                        else if (diff_q < 0)
                        begin
                            cx_reg <= CW'(-diff_q);
                            cy_reg <= -cy_reg;
                        end
                        else
                            cx_reg <= CW'(diff_q);
                    end
                    OP_PRED:  sum_reg <= AW'(prev_tilt_reg) + prod_q;
                    OP_TGYR:  sum_reg <= prod_q;
                    OP_TACC:  sum_reg <= sum_reg + prod_q;
                    OP_UANG:  sum_reg <= prod_q;
                    OP_URATE: sum_reg <= sum_reg + prod_q;
                    OP_UWHL:  sum_reg <= sum_reg + prod_q;
                    default: ;
                endcase
            end
            S_CORD:
            begin
                cx_reg <= cx_nx;
                cy_reg <= cy_nx;
                z_reg  <= z_nx;
                if (cord_cnt_reg == CSW'(CORDIC_STEPS - 1))
                    acc_tilt_reg <= AW'(z_nx) + bias_ext;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    tilt_reg   <= prev_tilt_reg;
                    en_reg     <= en_nx;
                    torque_reg <= en_nx ? sat32(-sum_reg) : 32'sd0;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[design/tebc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module tebc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pready,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] torque_cmd,
    input wire logic               drive_enabled
);

    // one item in flight: no new transfer right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // drive is zero outside the window
    a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_enabled) |-> (torque_cmd == 32'sd0))
        else $error("torque outside window");

    // a result cannot appear in the cycle right after an input transfer
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        ((in_valid && in_ready) && !out_valid) |=> !out_valid)
        else $error("result too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(torque_cmd)))
        else $error("result dropped while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind tilt_estimate_and_balance_control tebc_checker u_tebc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .torque_cmd(torque_cmd),
    .drive_enabled(drive_enabled)
);
`default_nettype wire
